FILE: hw/rtl/bb3_pkg.sv
package bb3_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int MAX_DIGITS_DEF = 20;
  localparam int DIGIT_TAB      = 26;
  localparam int CNT_W          = $clog2(DIGIT_TAB + 1);

  function automatic logic [63:0] pow3(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) begin
      p = p * 64'd3;
    end
    return p;
  endfunction

  function automatic logic [63:0] rep_base(input int k);
    return (pow3(k) - 64'd1) >> 1;
  endfunction

endpackage

FILE: hw/rtl/bijective_base3_converter_core.sv
// Bijective base-3 converter core.
// Input channel (in_valid/in_ready/in_value) takes one binary number per
// transfer. Output channel (out_valid/out_ready) returns its digits 1..3
// one per transfer, most significant first, out_last_digit marking the
// final one. A zero value, or one needing more than MAX_DIGITS digits,
// gives a single transfer with out_digit 0, out_error 1, out_last_digit 1.
// Three register stages (threshold compare, digit count encode, offset
// subtract) feed a digit serializer; a number passes through them in
// that order before its first digit is offered on the output channel.
// A new number enters every cycle while the stages have room; sustained
// throughput is set by the serializer, which sends one digit per cycle
// while out_ready is high, so a number with n digits takes n transfers.
// Reset (rst_n low, synchronous) empties every stage and the serializer.
// When the receiver holds out_ready low the current digit stays on the
// port, the stages fill up behind it and in_ready drops; nothing is lost.
module bijective_base3_converter_core
  import bb3_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_digit,
  output logic                  out_last_digit,
  output logic                  out_error
);

  localparam int CW = VALUE_BITS + 2;
  localparam int PW = $clog2(MAX_DIGITS);

  function automatic logic [CW-1:0] sat(input logic [63:0] x);
    if ((x >> CW) != 64'd0) begin
      return {CW{1'b1}};
    end
    return x[CW-1:0];
  endfunction

  logic [CW-1:0] rep_tab [DIGIT_TAB+1];
  logic [CW-1:0] p1_tab  [MAX_DIGITS];
  logic [CW-1:0] p2_tab  [MAX_DIGITS];

  for (genvar g = 0; g <= DIGIT_TAB; g++) begin : g_rep
    assign rep_tab[g] = sat(rep_base(g));
  end
  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_pow
    assign p1_tab[g] = sat(pow3(g));
    assign p2_tab[g] = sat(pow3(g) * 64'd2);
  end

  logic                  s1_v_r, s2_v_r, s3_v_r, ser_v_r;
  logic [VALUE_BITS-1:0] s1_val_r, s2_val_r, s3_w_r, ser_w_r;
  logic [DIGIT_TAB:1]    s1_ge_r;
  logic [CNT_W-1:0]      s2_n_r;
  logic [PW-1:0]         s3_pos_r, ser_pos_r;
  logic                  s3_err_r, ser_err_r;

  logic                  ser_load, s3_rdy, s2_rdy, s1_rdy;
  logic [DIGIT_TAB:1]    ge_nxt;
  logic [CNT_W-1:0]      n_nxt;
  logic [VALUE_BITS-1:0] w_nxt, ser_w_nxt;
  logic                  err_nxt;
  logic [PW-1:0]         pos_nxt;
  logic [CW-1:0]         ser_w_ext, p1, p2;
  logic                  ge1, ge2;

  assign ser_load = s3_v_r && (!ser_v_r || (out_ready && out_last_digit));
  assign s3_rdy   = !s3_v_r || ser_load;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  for (genvar g = 1; g <= DIGIT_TAB; g++) begin : g_ge
    assign ge_nxt[g] = ({2'b00, in_value} >= rep_tab[g]);
  end

  always_comb begin
    n_nxt = '0;
    for (int k = 1; k <= DIGIT_TAB; k++) begin
      if (s1_ge_r[k] && ((k == DIGIT_TAB) || !s1_ge_r[(k == DIGIT_TAB) ? k : k + 1])) begin
        n_nxt = n_nxt | CNT_W'(k);
      end
    end
  end

  always_comb begin
    logic [CW-1:0] r;
    r       = rep_tab[s2_n_r];
    w_nxt   = s2_val_r - r[VALUE_BITS-1:0];
    err_nxt = (s2_n_r == '0) || (32'(s2_n_r) > MAX_DIGITS);
    pos_nxt = err_nxt ? '0 : PW'(s2_n_r - CNT_W'(1));
  end

  assign ser_w_ext = {2'b00, ser_w_r};
  assign p1        = p1_tab[ser_pos_r];
  assign p2        = p2_tab[ser_pos_r];
  assign ge2       = (ser_w_ext >= p2);
  assign ge1       = (ser_w_ext >= p1);

  always_comb begin
    logic [CW-1:0] sub;
    sub       = ge2 ? p2 : (ge1 ? p1 : '0);
    ser_w_nxt = ser_w_r - sub[VALUE_BITS-1:0];
  end

  assign out_valid      = ser_v_r;
  assign out_error      = ser_err_r;
  assign out_last_digit = ser_err_r || (ser_pos_r == '0);
  assign out_digit      = ser_err_r ? 2'd0 : (ge2 ? 2'd3 : (ge1 ? 2'd2 : 2'd1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      ser_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
      if (ser_load) begin
        ser_v_r <= 1'b1;
      end else if (out_ready && out_last_digit) begin
        ser_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_val_r <= in_value;
      s1_ge_r  <= ge_nxt;
    end
    if (s2_rdy) begin
      s2_val_r <= s1_val_r;
      s2_n_r   <= n_nxt;
    end
    if (s3_rdy) begin
      s3_w_r   <= w_nxt;
      s3_pos_r <= pos_nxt;
      s3_err_r <= err_nxt;
    end
    if (ser_load) begin
      ser_w_r   <= s3_w_r;
      ser_pos_r <= s3_pos_r;
      ser_err_r <= s3_err_r;
    end else if (ser_v_r && out_ready) begin
      ser_w_r   <= ser_w_nxt;
      ser_pos_r <= ser_pos_r - PW'(1);
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last_digit && out_digit == 2'd0)
    else $error("error transfer not marked last");

  a_digit_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error |-> out_digit != 2'd0)
    else $error("zero digit without error");

  a_final_rem: assert property (@(posedge clk) disable iff (!rst_n)
    ser_v_r && !ser_err_r && ser_pos_r == '0 |-> ser_w_r < VALUE_BITS'(3))
    else $error("remainder left at final digit");

  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ser_v_r && !(out_ready && out_last_digit) |=> ser_v_r)
    else $error("serializer dropped a number");

endmodule
